/* hdl/sspm_pkg.sv */
// Shared types and constants of the sparse spike max pooling unit.
// Field widths, configuration register indexes and reset values.
// No dependencies.
package sspm_pkg;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KERNEL_HEIGHT = 3'd0,
    REG_KERNEL_WIDTH  = 3'd1,
    REG_PAD_TOP       = 3'd2,
    REG_PAD_LEFT      = 3'd3,
    REG_OUT_HEIGHT    = 3'd4,
    REG_OUT_WIDTH     = 3'd5
  } cfg_reg_t;

  // Field widths.
  localparam int KERNEL_W  = 5;
  localparam int PAD_W     = 4;
  localparam int BOUND_W   = 8;
  localparam int CHANNEL_W = 5;
  localparam int COORD_W   = 10;
  localparam int TS_W      = 8;
  localparam int POOLED_W  = 7;
  // Padded coordinate and full quotient (1023 + 15 needs 11 bits).
  localparam int QUOT_W    = 11;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;

  // Commands carried in the input tuser bit.
  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_SPIKE = 1'b1;

  // Register reset values.
  localparam logic [KERNEL_W-1:0] KERNEL_RESET = 5'd2;
  localparam logic [PAD_W-1:0]    PAD_RESET    = 4'd0;
  localparam logic [BOUND_W-1:0]  BOUND_RESET  = 8'd128;

endpackage

/* hdl/sparse_spike_max_pool_unit.sv */
// Sparse spike max pooling unit: first spike into each pooled cell wins.
// Holds the seen bitmap memory, the parallel row and column dividers and the control.
// Depends on sspm_pkg.
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ------------------------------------------
//  s_*      in         s_tvalid / s_tready  tuser: cmd; tdata: channel,row,col,time_step
//  m_*      out        m_tvalid / m_tready  tdata: out_channel,out_row,out_col,out_time_step
//  cfg_*    in         cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// After acceptance a spike beat passes through the bit-serial divider (one
// quotient bit per cycle for row and column together), the bounds check and
// bitmap read, and the test and set of the bit before its result can be
// offered. One spike is in flight at a time.
// A clear beat, and reset itself, start a clearing pass that writes one bitmap
// row per cycle over CHANNELS rounded up to a power of two times OUT_DIM
// rounded up to a power of two rows (4096 at the defaults). No beat is accepted
// then; configuration writes are always taken.
// A finished result waits in the output register without blocking the next
// input beat; only the final bit test and set stalls on a full output register.
module sparse_spike_max_pool_unit
  import sspm_pkg::*;
#(
  parameter int CHANNELS = 32,
  parameter int OUT_DIM  = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input spikes and clear commands.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata from bit 0: channel[4:0], row[14:5], col[24:15], time_step[32:25], zeros
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // tuser: cmd (0 clears the seen map, 1 is a spike)
  input  logic                   s_tuser,
  // Pooled spikes.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata from bit 0: out_channel[4:0], out_row[11:5], out_col[18:12],
  // out_time_step[26:19], zeros
  output logic [M_TDATA_W-1:0]   m_tdata,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Bitmap geometry: one memory row per (channel, pooled row), one bit per
  // pooled column inside the row.
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W     = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
  localparam int ADDR_W    = CH_W + POS_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam logic [QUOT_W-1:0] OUT_DIM_Q = QUOT_W'(OUT_DIM);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
  localparam int DIV_STEPS = QUOT_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_LOOK,
    S_CHECK
  } state_t;

  state_t state;

  // Configuration registers.
  logic [KERNEL_W-1:0] kernel_height;
  logic [KERNEL_W-1:0] kernel_width;
  logic [PAD_W-1:0]    pad_top;
  logic [PAD_W-1:0]    pad_left;
  logic [BOUND_W-1:0]  out_height;
  logic [BOUND_W-1:0]  out_width;

  // Item being worked on.
  logic [ADDR_W-1:0]    clr_addr;
  logic [CNT_W-1:0]     step;
  logic [CH_W-1:0]      ch_idx;
  logic [CHANNEL_W-1:0] ch;
  logic                 ch_ok;
  logic [TS_W-1:0]      ts;
  logic [QUOT_W-1:0]    py;        // dividend shifting out, quotient shifting in
  logic [QUOT_W-1:0]    px;
  logic [KERNEL_W-1:0]  rem_y;
  logic [KERNEL_W-1:0]  rem_x;

  // Output register.
  logic [CHANNEL_W-1:0] out_channel;
  logic [POOLED_W-1:0]  out_row;
  logic [POOLED_W-1:0]  out_col;
  logic [TS_W-1:0]      out_time_step;

  // Input fields.
  logic [CHANNEL_W-1:0] in_channel;
  logic [COORD_W-1:0]   in_row;
  logic [COORD_W-1:0]   in_col;
  logic [TS_W-1:0]      in_time_step;

  assign in_channel   = s_tdata[4:0];
  assign in_row       = s_tdata[14:5];
  assign in_col       = s_tdata[24:15];
  assign in_time_step = s_tdata[32:25];

  // A zero kernel behaves as one.
  logic [KERNEL_W-1:0] kh_eff;
  logic [KERNEL_W-1:0] kw_eff;
  assign kh_eff = (kernel_height == '0) ? KERNEL_W'(1) : kernel_height;
  assign kw_eff = (kernel_width == '0) ? KERNEL_W'(1) : kernel_width;

  // Bounds above OUT_DIM act as OUT_DIM.
  logic [QUOT_W-1:0] bound_h;
  logic [QUOT_W-1:0] bound_w;
  assign bound_h = (QUOT_W'(out_height) > OUT_DIM_Q) ? OUT_DIM_Q : QUOT_W'(out_height);
  assign bound_w = (QUOT_W'(out_width) > OUT_DIM_Q) ? OUT_DIM_Q : QUOT_W'(out_width);

  // One restoring division step for row and column.
  logic [KERNEL_W:0]   trial_y;
  logic [KERNEL_W:0]   trial_x;
  logic                ge_y;
  logic                ge_x;
  logic [KERNEL_W-1:0] rem_y_next;
  logic [KERNEL_W-1:0] rem_x_next;

  assign trial_y    = {rem_y, py[QUOT_W-1]};
  assign trial_x    = {rem_x, px[QUOT_W-1]};
  assign ge_y       = trial_y >= {1'b0, kh_eff};
  assign ge_x       = trial_x >= {1'b0, kw_eff};
  assign rem_y_next = ge_y ? KERNEL_W'(trial_y - {1'b0, kh_eff}) : trial_y[KERNEL_W-1:0];
  assign rem_x_next = ge_x ? KERNEL_W'(trial_x - {1'b0, kw_eff}) : trial_x[KERNEL_W-1:0];

  // Bitmap access.
  logic [OUT_DIM-1:0] seen_mem [MEM_DEPTH];
  logic [OUT_DIM-1:0] rd_word;
  logic [ADDR_W-1:0]  look_addr;
  logic [POS_W-1:0]   px_idx;
  logic               in_bounds;
  logic               out_free;
  logic               emit;
  logic               mem_we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [OUT_DIM-1:0] wr_word;
  logic               accept;

  assign look_addr = {ch_idx, py[POS_W-1:0]};
  assign px_idx    = px[POS_W-1:0];
  assign in_bounds = ch_ok && (py < bound_h) && (px < bound_w);
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = (state == S_CHECK) && !rd_word[px_idx] && out_free;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = look_addr;
    wr_word = rd_word;
    if (state == S_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_addr;
      wr_word = '0;
    end else if (emit) begin
      mem_we          = 1'b1;
      wr_word[px_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_mem[wr_addr] <= wr_word;
    end
    rd_word <= seen_mem[look_addr];
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {5'b0, out_time_step, out_col, out_row, out_channel};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_height <= KERNEL_RESET;
      kernel_width  <= KERNEL_RESET;
      pad_top       <= PAD_RESET;
      pad_left      <= PAD_RESET;
      out_height    <= BOUND_RESET;
      out_width     <= BOUND_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[KERNEL_W-1:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[KERNEL_W-1:0];
        REG_PAD_TOP:       pad_top       <= cfg_data[PAD_W-1:0];
        REG_PAD_LEFT:      pad_left      <= cfg_data[PAD_W-1:0];
        REG_OUT_HEIGHT:    out_height    <= cfg_data;
        REG_OUT_WIDTH:     out_width     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A new result may replace the one leaving at the same edge.
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == CMD_CLEAR) begin
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (step == LAST_STEP) begin
            step  <= '0;
            state <= S_LOOK;
          end else begin
            step <= step + CNT_W'(1);
          end
        end
        S_LOOK: begin
          // The bitmap row is read at this edge; the check follows only when the cell is in bounds.
          state <= in_bounds ? S_CHECK : S_IDLE;
        end
        S_CHECK: begin
          if (rd_word[px_idx] || out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      ch     <= in_channel;
      ch_idx <= CH_W'(in_channel);
      ch_ok  <= 32'(in_channel) < CHANNELS;
      ts     <= in_time_step;
      py     <= QUOT_W'(in_row) + QUOT_W'(pad_top);
      px     <= QUOT_W'(in_col) + QUOT_W'(pad_left);
      rem_y  <= '0;
      rem_x  <= '0;
    end else if (state == S_DIV) begin
      py    <= {py[QUOT_W-2:0], ge_y};
      px    <= {px[QUOT_W-2:0], ge_x};
      rem_y <= rem_y_next;
      rem_x <= rem_x_next;
    end
    if (emit) begin
      out_channel   <= ch;
      out_row       <= py[POOLED_W-1:0];
      out_col       <= px[POOLED_W-1:0];
      out_time_step <= ts;
    end
  end

  // An accepted beat always moves the sequencer out of idle.
  assert property (@(posedge clk) disable iff (rst) accept |=> state != S_IDLE)
    else $error("accepted beat left the sequencer idle");

  // The clearing pass blocks input and writes zero rows.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!s_tready && mem_we && wr_word == '0))
    else $error("clearing pass not writing zeros or not blocking input");

  // A result is only produced for a cell inside the pooled map.
  assert property (@(posedge clk) disable iff (rst)
    emit |-> (ch_ok && (py < bound_h) && (px < bound_w)))
    else $error("result emitted for an out-of-bounds cell");

  // Leaving reset starts a full clearing pass from the first row.
  assert property (@(posedge clk) $fell(rst) |-> (state == S_CLEAR && clr_addr == '0))
    else $error("reset did not start a clearing pass");

endmodule
